// ===== rtl/ksem_pkg.sv =====
// ----------------------------------------------------------------------------
// ksem_pkg: shared types and codes for the keyed semaphore table
// Request/result payload structs, status codes and request-type codes.
// ----------------------------------------------------------------------------
package ksem_pkg;

    localparam int unsigned COUNT_W = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [2:0] {
        ST_ACQUIRED = 3'd0,
        ST_QUEUED   = 3'd1,
        ST_WOKEN    = 3'd2,
        ST_UPDONE   = 3'd3,
        ST_NOSPACE  = 3'd4
    } status_t;

    typedef enum logic {
        REQ_DOWN = 1'b0,
        REQ_UP   = 1'b1
    } req_type_t;

    typedef struct packed {
        logic        req_type;
        logic [31:0] sem_key;
        logic [15:0] waiter_id;
        logic [15:0] release_count;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] value;
        logic [15:0] woken_id;
        logic        last;
    } rsp_t;

endpackage

// ===== rtl/ksem_ram.sv =====
// ----------------------------------------------------------------------------
// ksem_ram: generic single-port-write, single-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ksem_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/ksem_front.sv =====
// ----------------------------------------------------------------------------
// ksem_front: key lookup and entry allocation
// Matches the key against the table, allocates on first use, and hands the
// entry index (or table-full) to the back end through a two-deep queue.
// ----------------------------------------------------------------------------
module ksem_front #(
    parameter int unsigned KEY_ENTRIES = 16,
    parameter int unsigned KEY_BITS    = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  ksem_pkg::req_t                 in_req,
    output logic                           q_valid,
    input  logic                           q_ready,
    output ksem_pkg::req_t                 q_req,
    output logic [$clog2(KEY_ENTRIES)-1:0] q_entry,
    output logic                           q_full_tbl,
    output logic                           q_fresh
);
    import ksem_pkg::*;

    localparam int unsigned EW = $clog2(KEY_ENTRIES);

    typedef struct packed {
        req_t          req;
        logic [EW-1:0] entry;
        logic          full_tbl;
        logic          fresh;
    } hand_t;

    logic [KEY_ENTRIES-1:0] valid_reg;
    logic [KEY_BITS-1:0]    key_reg [KEY_ENTRIES];

    hand_t       slot_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  cnt_reg;

    logic [KEY_BITS-1:0] key;
    logic [EW-1:0]       hit_idx, free_idx;
    logic                hit, has_free;
    logic                push, pop;
    hand_t               h;

    assign key = KEY_BITS'(in_req.sem_key);

    always_comb
    begin
        hit      = 1'b0;
        has_free = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int i = KEY_ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && key_reg[i] == key)
            begin
                hit     = 1'b1;
                hit_idx = EW'(i);
            end
            if (!valid_reg[i])
            begin
                has_free = 1'b1;
                free_idx = EW'(i);
            end
        end
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        h.req      = in_req;
        h.entry    = hit ? hit_idx : free_idx;
        h.full_tbl = !hit && !has_free;
        h.fresh    = !hit && has_free;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= h;
            if (h.fresh)
            begin
                key_reg[free_idx] <= key;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
                if (h.fresh)
                begin
                    valid_reg[free_idx] <= 1'b1;
                end
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    assign q_valid    = (cnt_reg != 2'd0);
    assign q_req      = slot_reg[rd_ptr_reg].req;
    assign q_entry    = slot_reg[rd_ptr_reg].entry;
    assign q_full_tbl = slot_reg[rd_ptr_reg].full_tbl;
    assign q_fresh    = slot_reg[rd_ptr_reg].fresh;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("handoff queue count out of range");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !push) else $error("push into full handoff queue");
    a_fresh_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        push && h.fresh |=> valid_reg[$past(free_idx)])
        else $error("fresh entry not marked valid");
endmodule

// ===== rtl/ksem_back.sv =====
// ----------------------------------------------------------------------------
// ksem_back: semaphore execution engine
// Applies down/up to the entry state and the waiter pool, passing its results
// one at a time through a single output register.
// ----------------------------------------------------------------------------
module ksem_back #(
    parameter int unsigned KEY_ENTRIES  = 16,
    parameter int unsigned WAITER_SLOTS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    output logic                           q_ready,
    input  ksem_pkg::req_t                 q_req,
    input  logic [$clog2(KEY_ENTRIES)-1:0] q_entry,
    input  logic                           q_full_tbl,
    input  logic                           q_fresh,
    output logic                           out_valid,
    input  logic                           out_ready,
    output ksem_pkg::rsp_t                 out_rsp
);
    import ksem_pkg::*;

    localparam int unsigned EW = $clog2(KEY_ENTRIES);
    localparam int unsigned SW = $clog2(WAITER_SLOTS);
    localparam int unsigned LW = $clog2(WAITER_SLOTS + 1);
    localparam int unsigned WAKE_LIMIT = 16;
    localparam int unsigned WL = $clog2(WAKE_LIMIT + 1);

    typedef enum logic [1:0] {S_IDLE, S_WAKE_RD, S_WAKE, S_DONE} state_t;

    // per-entry state (small, read at the incoming or the held entry index)
    logic [COUNT_W-1:0] count_reg [KEY_ENTRIES];
    logic [SW-1:0]      head_reg  [KEY_ENTRIES];
    logic [SW-1:0]      tail_reg  [KEY_ENTRIES];
    logic [LW-1:0]      len_reg   [KEY_ENTRIES];
    logic [WAITER_SLOTS-1:0] free_reg;

    state_t             state_reg;
    logic [EW-1:0]      ent_reg;
    logic [15:0]        num_reg;
    logic [WL-1:0]      woken_reg;
    rsp_t               rsp_reg;
    logic               ov_reg;

    // pool memories
    logic               pw_we;
    logic [SW-1:0]      pw_waddr, p_raddr;
    logic [15:0]        pw_wdata, pw_rdata;
    logic               pn_we;
    logic [SW-1:0]      pn_waddr, pn_wdata, pn_rdata;

    ksem_ram #(.WIDTH(16), .DEPTH(WAITER_SLOTS)) u_waiter (
        .clk(clk), .we(pw_we), .waddr(pw_waddr), .wdata(pw_wdata),
        .raddr(p_raddr), .rdata(pw_rdata));
    ksem_ram #(.WIDTH(SW), .DEPTH(WAITER_SLOTS)) u_next (
        .clk(clk), .we(pn_we), .waddr(pn_waddr), .wdata(pn_wdata),
        .raddr(p_raddr), .rdata(pn_rdata));

    logic               out_free;
    logic               take;
    logic               rsp_load;
    logic [COUNT_W-1:0] cur_count;
    logic [LW-1:0]      cur_len;
    logic [SW-1:0]      slot;
    logic               has_slot;
    logic [16:0]        sum;

    assign out_free = !ov_reg || out_ready;
    assign q_ready  = (state_reg == S_IDLE) && out_free;
    assign take     = q_valid && q_ready;

    // a new result enters the output register this cycle
    assign rsp_load = (take && (q_full_tbl || q_req.req_type == REQ_DOWN))
                   || ((state_reg == S_WAKE || state_reg == S_DONE) && out_free);

    assign cur_count = q_fresh ? '0 : count_reg[q_entry];
    assign cur_len   = q_fresh ? '0 : len_reg[q_entry];
    assign p_raddr   = head_reg[ent_reg];

    always_comb
    begin
        has_slot = 1'b0;
        slot     = '0;
        for (int i = WAITER_SLOTS - 1; i >= 0; i--)
        begin
            if (free_reg[i])
            begin
                has_slot = 1'b1;
                slot     = SW'(i);
            end
        end
    end

    // enqueue writes into the pool
    always_comb
    begin
        pw_we    = 1'b0;
        pn_we    = 1'b0;
        pw_waddr = slot;
        pw_wdata = q_req.waiter_id;
        pn_waddr = tail_reg[q_entry];
        pn_wdata = slot;
        if (take && !q_full_tbl && q_req.req_type == REQ_DOWN
            && cur_count == '0 && has_slot)
        begin
            pw_we = 1'b1;
            pn_we = (cur_len != '0);
        end
    end

    assign sum = {1'b0, count_reg[ent_reg]} + {1'b0, num_reg};

    always_ff @(posedge clk)
    begin
        if (take && !q_full_tbl)
        begin
            if (q_req.req_type == REQ_DOWN)
            begin
                if (cur_count != '0)
                begin
                    count_reg[q_entry] <= cur_count - 1'b1;
                end
                else if (has_slot)
                begin
                    if (q_fresh)
                    begin
                        count_reg[q_entry] <= '0;
                    end
                    if (cur_len == '0)
                    begin
                        head_reg[q_entry] <= slot;
                    end
                    tail_reg[q_entry] <= slot;
                    len_reg[q_entry]  <= cur_len + 1'b1;
                end
                else if (q_fresh)
                begin
                    count_reg[q_entry] <= '0;
                    len_reg[q_entry]   <= '0;
                end
            end
            else if (q_fresh)
            begin
                count_reg[q_entry] <= '0;
                len_reg[q_entry]   <= '0;
            end
        end
        if (state_reg == S_WAKE && out_free)
        begin
            head_reg[ent_reg] <= pn_rdata;
            len_reg[ent_reg]  <= len_reg[ent_reg] - 1'b1;
        end
        if (state_reg == S_DONE && out_free)
        begin
            count_reg[ent_reg] <= sum[16] ? COUNT_MAX : sum[15:0];
        end
        if (take)
        begin
            ent_reg <= q_entry;
            num_reg <= q_req.release_count;
        end
        else if (state_reg == S_WAKE && out_free)
        begin
            num_reg <= num_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            free_reg  <= '1;
            woken_reg <= '0;
            rsp_reg   <= '0;
        end
        else
        begin
            if (rsp_load)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (take)
                    begin
                        woken_reg <= '0;
                        if (q_full_tbl)
                        begin
                            rsp_reg <= '{ST_NOSPACE, '0, '0, 1'b1};
                        end
                        else if (q_req.req_type == REQ_DOWN)
                        begin
                            if (cur_count != '0)
                            begin
                                rsp_reg <= '{ST_ACQUIRED, cur_count, '0, 1'b1};
                            end
                            else if (has_slot)
                            begin
                                rsp_reg        <= '{ST_QUEUED, '0, '0, 1'b1};
                                free_reg[slot] <= 1'b0;
                            end
                            else
                            begin
                                rsp_reg <= '{ST_NOSPACE, '0, '0, 1'b1};
                            end
                        end
                        else if (q_req.release_count != '0 && cur_len != '0)
                        begin
                            state_reg <= S_WAKE_RD;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_WAKE_RD:
                begin
                    state_reg <= S_WAKE;
                end
                S_WAKE:
                begin
                    if (out_free)
                    begin
                        rsp_reg           <= '{ST_WOKEN, '0, pw_rdata, 1'b0};
                        free_reg[p_raddr] <= 1'b1;
                        woken_reg         <= woken_reg + 1'b1;
                        if (num_reg == 16'd1 || len_reg[ent_reg] == LW'(1)
                            || woken_reg == WL'(WAKE_LIMIT - 1))
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_WAKE_RD;
                        end
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        rsp_reg   <= '{ST_UPDONE, 16'(woken_reg), '0, 1'b1};
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = ov_reg;
    assign out_rsp   = rsp_reg;

    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> state_reg == S_IDLE) else $error("accept while busy");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && !out_ready |=> ov_reg && $stable(rsp_reg))
        else $error("result dropped under stall");
    a_wake_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WAKE |-> len_reg[ent_reg] != '0)
        else $error("wake from empty queue");
endmodule

// ===== rtl/keyed_semaphore_table.sv =====
// A request passes the front end's handoff queue, then the back end, which loads a
// down or table-full result as it takes the request; these follow back to back while
// the output is free. An up request blocks others while it steps S_WAKE_RD, then
// S_WAKE per waiter woken (pool RAM read, then result), then S_DONE for up-done.
// Reset clears entry valid bits, the pool free map and all control; no sweep.
// ----------------------------------------------------------------------------
// keyed_semaphore_table: table of counting semaphores named by a key
// Front end matches/allocates keys; back end runs down/up against the
// per-entry counts and the shared waiter pool.
// ----------------------------------------------------------------------------
module keyed_semaphore_table #(
    parameter int unsigned KEY_ENTRIES  = 16,
    parameter int unsigned WAITER_SLOTS = 16,
    parameter int unsigned KEY_BITS     = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  ksem_pkg::req_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output ksem_pkg::rsp_t  out_data
);
    import ksem_pkg::*;

    // handoff between front and back: a two-entry queue inside the front
    logic                           q_valid, q_ready, q_full_tbl, q_fresh;
    req_t                           q_req;
    logic [$clog2(KEY_ENTRIES)-1:0] q_entry;

    ksem_front #(.KEY_ENTRIES(KEY_ENTRIES), .KEY_BITS(KEY_BITS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_req(in_data),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
        .q_entry(q_entry), .q_full_tbl(q_full_tbl), .q_fresh(q_fresh));

    // execution: one result transfer at a time from a single output register
    ksem_back #(.KEY_ENTRIES(KEY_ENTRIES), .WAITER_SLOTS(WAITER_SLOTS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
        .q_entry(q_entry), .q_full_tbl(q_full_tbl), .q_fresh(q_fresh),
        .out_valid(out_valid), .out_ready(out_ready), .out_rsp(out_data));
endmodule

// ===== test/keyed_semaphore_table_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_semaphore_table_test: self-checking bench for the semaphore table
// Drives down/up requests over a handful of keys with bursty input and a
// stalling receiver; a local table model predicts every result in order.
// ----------------------------------------------------------------------------
module keyed_semaphore_table_test;
    import ksem_pkg::*;

    localparam int ENTRIES    = 16;
    localparam int SLOTS      = 16;
    localparam int WAKE_MAX   = 16;
    localparam int IDLE_LIMIT = 5000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    req_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    rsp_t out_data;

    keyed_semaphore_table dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // model state of the table and the waiter pool
    bit          sem_used [ENTRIES];
    logic [31:0] sem_key_tab [ENTRIES];
    int          sem_count [ENTRIES];
    int          sem_head [ENTRIES];
    int          sem_tail [ENTRIES];
    int          sem_len [ENTRIES];
    logic [15:0] slot_waiter [SLOTS];
    int          slot_next [SLOTS];
    bit          slot_free [SLOTS];

    req_t pending_reqs [$];
    rsp_t expected_rsps [$];
    int   errors = 0;
    bit   hold_sender = 1'b0;
    bit   stim_done = 1'b0;
    int   burst_left = 0;
    int   gap_left = 0;
    int   idle_cycles = 0;
    logic [31:0] key_pool [8];

    // in_ready_q tracks whether the item on the bus was taken at the last edge
    logic in_ready_q = 1'b1;

    task automatic report(input string what);
        errors++;
        $display("mismatch: %s", what);
    endtask

    function automatic rsp_t mk_rsp(status_t st, int val, logic [15:0] wid, bit lst);
        rsp_t r;
        r.status = st;
        r.value = val[15:0];
        r.woken_id = wid;
        r.last = lst;
        return r;
    endfunction

    // Predict the results of one request and append them to expected_rsps.
    task automatic predict_semaphore(input req_t rq);
        int e;
        int s;
        int num;
        int woken;
        int h;
        e = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (sem_used[i] && sem_key_tab[i] == rq.sem_key && e < 0)
                e = i;
        if (e < 0)
        begin
            for (int i = 0; i < ENTRIES; i++)
                if (!sem_used[i] && e < 0)
                    e = i;
            if (e >= 0)
            begin
                sem_used[e] = 1'b1;
                sem_key_tab[e] = rq.sem_key;
                sem_count[e] = 0;
                sem_head[e] = 0;
                sem_tail[e] = 0;
                sem_len[e] = 0;
            end
        end
        if (e < 0)
        begin
            expected_rsps.push_back(mk_rsp(ST_NOSPACE, 0, '0, 1'b1));
            return;
        end
        if (rq.req_type == REQ_DOWN)
        begin
            if (sem_count[e] > 0)
            begin
                expected_rsps.push_back(mk_rsp(ST_ACQUIRED, sem_count[e], '0, 1'b1));
                sem_count[e]--;
                return;
            end
            s = -1;
            for (int i = 0; i < SLOTS; i++)
                if (slot_free[i] && s < 0)
                    s = i;
            if (s < 0)
            begin
                expected_rsps.push_back(mk_rsp(ST_NOSPACE, 0, '0, 1'b1));
                return;
            end
            slot_free[s] = 1'b0;
            slot_waiter[s] = rq.waiter_id;
            slot_next[s] = 0;
            if (sem_len[e] == 0)
                sem_head[e] = s;
            else
                slot_next[sem_tail[e]] = s;
            sem_tail[e] = s;
            sem_len[e]++;
            expected_rsps.push_back(mk_rsp(ST_QUEUED, 0, '0, 1'b1));
            return;
        end
        num = rq.release_count;
        woken = 0;
        while (num > 0 && sem_len[e] > 0 && woken < WAKE_MAX)
        begin
            h = sem_head[e];
            expected_rsps.push_back(mk_rsp(ST_WOKEN, 0, slot_waiter[h], 1'b0));
            slot_free[h] = 1'b1;
            sem_head[e] = slot_next[h];
            sem_len[e]--;
            num--;
            woken++;
        end
        sem_count[e] = (sem_count[e] + num > 65535) ? 65535 : sem_count[e] + num;
        expected_rsps.push_back(mk_rsp(ST_UPDONE, woken, '0, 1'b1));
    endtask

    function automatic req_t mk_req(req_type_t t, logic [31:0] k, int wid, int cnt);
        req_t r;
        r.req_type = t;
        r.sem_key = k;
        r.waiter_id = wid[15:0];
        r.release_count = cnt[15:0];
        return r;
    endfunction

    // Driver: bursts with random gaps, payload changes only at the falling edge.
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !in_ready_q))
        begin
            if (pending_reqs.size() > 0 && !hold_sender && gap_left == 0)
            begin
                in_valid <= 1'b1;
                in_data <= pending_reqs.pop_front();
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 12);
                    if ($urandom_range(0, 3) != 0)
                        gap_left = $urandom_range(0, 6);
                end
                else
                    burst_left--;
            end
            else
            begin
                in_valid <= 1'b0;
                if (gap_left > 0)
                    gap_left--;
            end
        end
        // receiver stall pattern: long open stretches mixed with choppy ones
        if ($urandom_range(0, 63) < 32)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 3) != 0) && ($urandom_range(0, 1) != 0 ||
                         $urandom_range(0, 2) == 0);
    end

    // Monitor: predicts on input transfers, checks output transfers.
    always @(posedge clk)
    begin
        rsp_t exp_r;
        if (rst_n)
        begin
            in_ready_q <= !(in_valid && !in_ready);
            if (in_valid && in_ready)
                predict_semaphore(in_data);
            if (out_valid && out_ready)
            begin
                if (expected_rsps.size() == 0)
                    report($sformatf("unexpected result %p", out_data));
                else
                begin
                    exp_r = expected_rsps.pop_front();
                    if (out_data.status !== exp_r.status)
                        report($sformatf("status %0d, want %0d", out_data.status,
                                         exp_r.status));
                    if (out_data.value !== exp_r.value)
                        report($sformatf("value %0d, want %0d", out_data.value,
                                         exp_r.value));
                    if (out_data.woken_id !== exp_r.woken_id)
                        report($sformatf("woken_id %0h, want %0h", out_data.woken_id,
                                         exp_r.woken_id));
                    if (out_data.last !== exp_r.last)
                        report($sformatf("last %0b, want %0b", out_data.last,
                                         exp_r.last));
                end
            end
            // watchdog on cycles with no transfer while work is outstanding
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else if (expected_rsps.size() > 0 || in_valid)
            begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles >= IDLE_LIMIT)
                begin
                    $display("CHECK FAILED");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        int k;
        int roll;
        for (int i = 0; i < ENTRIES; i++)
            sem_used[i] = 1'b0;
        for (int i = 0; i < SLOTS; i++)
            slot_free[i] = 1'b1;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 8; i++)
            key_pool[i] = $urandom();

        // directed: field extremes, both operations, special cases
        pending_reqs.push_back(mk_req(REQ_UP, 32'h0, 16'hFFFF, 0));      // up by 0, new key
        pending_reqs.push_back(mk_req(REQ_DOWN, 32'h0, 16'hFFFF, 0));    // queue
        pending_reqs.push_back(mk_req(REQ_DOWN, 32'h0, 16'hFFFF, 0));    // duplicate id
        pending_reqs.push_back(mk_req(REQ_DOWN, 32'h0, 16'h0000, 0));
        pending_reqs.push_back(mk_req(REQ_UP, 32'h0, 0, 2));             // partial wake
        pending_reqs.push_back(mk_req(REQ_UP, 32'h0, 0, 16'hFFFF));      // wakes last waiter; next up saturates
        pending_reqs.push_back(mk_req(REQ_UP, 32'h0, 0, 16'hFFFF));
        pending_reqs.push_back(mk_req(REQ_DOWN, 32'h0, 0, 16'hFFFF));    // acquire at max
        pending_reqs.push_back(mk_req(REQ_DOWN, 32'hFFFF_FFFF, 16'h5A5A, 0));
        pending_reqs.push_back(mk_req(REQ_UP, 32'hFFFF_FFFF, 0, 1));
        // fill the table, then one key too many
        for (int i = 0; i < 14; i++)
            pending_reqs.push_back(mk_req(REQ_UP, 32'h1000 + i, 0, 1));
        pending_reqs.push_back(mk_req(REQ_DOWN, 32'hDEAD_BEEF, 0, 0));   // table full

        // wait for the directed part to drain before the random part
        hold_sender = 1'b0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;
        wait (pending_reqs.size() == 0 && !in_valid);
        wait (expected_rsps.size() == 0);

        // random: keys from a small set; downs dominate so the pool fills
        for (int n = 0; n < 180; n++)
        begin
            k = $urandom_range(0, 15);
            roll = $urandom_range(0, 99);
            if (roll < 60)
                pending_reqs.push_back(mk_req(REQ_DOWN,
                    (k < 2) ? key_pool[k] : 32'h1000 + k - 2, $urandom_range(0, 65535),
                    $urandom_range(0, 65535)));
            else
                pending_reqs.push_back(mk_req(REQ_UP,
                    (k < 2) ? key_pool[k] : 32'h1000 + k - 2, $urandom_range(0, 65535),
                    (roll < 90) ? $urandom_range(0, 5) : $urandom_range(0, 65535)));
            if (n == 90)
            begin
                // pause the sender until the block has fully drained
                wait (pending_reqs.size() == 0 && !in_valid);
                hold_sender = 1'b1;
                wait (expected_rsps.size() == 0);
                hold_sender = 1'b0;
            end
        end
        wait (pending_reqs.size() == 0 && !in_valid);
        wait (expected_rsps.size() == 0);
        repeat (20) @(posedge clk);
        if (errors == 0 && expected_rsps.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
